@@ rtl/twmr_pkg.sv @@
// twmr_pkg: shared constants and helpers for the three-word modular reducer.
// No dependencies; imported by every module of the block.
package twmr_pkg;

    localparam int DEFAULT_WORD_BITS = 64;
    localparam int FIELD_BITS        = 64;   // width of every word on the ports
    localparam int CFG_DATA_BITS     = 64;
    localparam int CFG_INDEX_BITS    = 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INVERSE = 1'b1;

    // leading zero count of a left-aligned 64-bit word, binary search
    function automatic logic [6:0] lzc64(input logic [63:0] x);
        logic [63:0] t;
        logic [6:0]  n;
        t = x;
        n = '0;
        if (t[63:32] == 32'd0)
        begin
            n = n + 7'd32;
            t = t << 32;
        end
        if (t[63:48] == 16'd0)
        begin
            n = n + 7'd16;
            t = t << 16;
        end
        if (t[63:56] == 8'd0)
        begin
            n = n + 7'd8;
            t = t << 8;
        end
        if (t[63:60] == 4'd0)
        begin
            n = n + 7'd4;
            t = t << 4;
        end
        if (t[63:62] == 2'd0)
        begin
            n = n + 7'd2;
            t = t << 2;
        end
        if (!t[63])
        begin
            n = n + 7'd1;
        end
        return n;
    endfunction

endpackage

@@ rtl/three_word_mod_preinv_reducer_core.sv @@
// Three-word modular reducer, top level: config registers, normalization,
// two division rounds, denormalization and output register.
// Depends on twmr_pkg, twmr_round (and through it twmr_mul).
//
// Usage:
//   Input stream s_*: one transaction carries a 192-bit dividend as three
//   words; the high word should be below the modulus. Output stream m_*:
//   one transaction per input, remainder in m_tdata, and m_tuser set when
//   the high word was not below the modulus (remainder then unspecified).
//   Config port: cfg_we/cfg_index/cfg_data write modulus (index 0) or the
//   precomputed inverse of the normalized modulus (index 1). Write only
//   while no transaction is in flight; the inverse is not checked.
// Timing:
//   Fully pipelined, one transaction per cycle unless the pipeline stalls (see Backpressure).
//   From input acceptance to m_tvalid: capture/leading-zero count, shift, an
//   8-stage round, partial remainder merge, a second 8-stage round, output
//   register. Each round holds two 2-stage multipliers built from four
//   half-word partial products.
// Reset:
//   Modulus returns to 1, inverse to all ones, all valid bits clear.
// Backpressure:
//   When m_tready is low the output register holds; stages behind it keep
//   moving while the last round stage is empty, so bubbles close up and
//   s_tready stays high. Otherwise the whole pipeline stalls together.
module three_word_mod_preinv_reducer_core
    import twmr_pkg::*;
#(
    parameter int WORD_BITS = DEFAULT_WORD_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write port
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [3*FIELD_BITS-1:0]   s_tdata,  // word_high, word_middle, word_low
    // output stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [FIELD_BITS-1:0]     m_tdata,  // remainder
    output logic                      m_tuser   // high_not_reduced
);

    localparam int W      = WORD_BITS;
    localparam int NB     = $clog2(W);
    localparam int SIDE1  = 3 * W + 2 + NB;   // l_hi, l_lo, v, flag, zero, norm
    localparam int SIDE2  = 2 + NB;           // flag, zero, norm

    // configuration
    logic [W-1:0] modulus_reg;
    logic [W-1:0] inverse_reg;

    // pipeline advance: output register free, being emptied, or fed a bubble
    logic adv;

    logic [W-1:0] in_high, in_mid, in_low;
    logic [63:0]  d_aligned;

    // stage A: capture, compare, leading zeros
    logic          sa_valid_reg;
    logic [W-1:0]  sa_h_reg, sa_m_reg, sa_l_reg, sa_d_reg, sa_v_reg;
    logic          sa_flag_reg, sa_zero_reg;
    logic [NB-1:0] sa_norm_reg;

    // stage B: normalize
    logic [2*W-1:0] hm_next, l_next;
    logic           sb_valid_reg;
    logic [W-1:0]   sb_u1_reg, sb_u0_reg, sb_dn_reg, sb_v_reg, sb_lhi_reg, sb_llo_reg;
    logic           sb_flag_reg, sb_zero_reg;
    logic [NB-1:0]  sb_norm_reg;

    // round 1
    logic             r1_valid;
    logic [W-1:0]     r1_r, r1_dn;
    logic [SIDE1-1:0] r1_side;
    logic [W-1:0]     r1_lhi, r1_llo, r1_v;
    logic [SIDE2-1:0] r1_rest;

    // stage C: next round operands
    logic             sc_valid_reg;
    logic [W-1:0]     sc_u1_reg, sc_u0_reg, sc_dn_reg, sc_v_reg;
    logic [SIDE2-1:0] sc_side_reg;

    // round 2
    logic             r2_valid;
    logic [W-1:0]     r2_r;
    logic [SIDE2-1:0] r2_side;
    logic             r2_flag, r2_zero;
    logic [NB-1:0]    r2_norm;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [FIELD_BITS-1:0] out_rem_reg, out_rem_next;
    logic                  out_flag_reg;

    assign in_high   = s_tdata[W-1:0];
    assign in_mid    = s_tdata[FIELD_BITS+W-1:FIELD_BITS];
    assign in_low    = s_tdata[2*FIELD_BITS+W-1:2*FIELD_BITS];
    assign d_aligned = 64'(modulus_reg) << (64 - W);

    assign adv      = !out_valid_reg || m_tready || !r2_valid;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= W'(1);
            inverse_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODULUS: modulus_reg <= cfg_data[W-1:0];
                REG_INVERSE: inverse_reg <= cfg_data[W-1:0];
                default:     ;
            endcase
        end
    end

    // stage A
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg <= 1'b0;
            sb_valid_reg <= 1'b0;
            sc_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sa_valid_reg <= s_tvalid;
            sb_valid_reg <= sa_valid_reg;
            sc_valid_reg <= r1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_h_reg    <= in_high;
            sa_m_reg    <= in_mid;
            sa_l_reg    <= in_low;
            sa_d_reg    <= modulus_reg;
            sa_v_reg    <= inverse_reg;
            sa_flag_reg <= (in_high >= modulus_reg);
            sa_zero_reg <= (modulus_reg == '0);
            sa_norm_reg <= NB'(lzc64(d_aligned));
        end
    end

    // stage B: shift dividend pieces and modulus left by the leading zeros
    always_comb
    begin
        hm_next = {sa_h_reg, sa_m_reg} << sa_norm_reg;
        l_next  = {{W{1'b0}}, sa_l_reg} << sa_norm_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_u1_reg   <= hm_next[2*W-1:W];
            sb_u0_reg   <= hm_next[W-1:0];
            sb_dn_reg   <= sa_d_reg << sa_norm_reg;
            sb_v_reg    <= sa_v_reg;
            sb_lhi_reg  <= l_next[2*W-1:W];
            sb_llo_reg  <= l_next[W-1:0];
            sb_flag_reg <= sa_flag_reg;
            sb_zero_reg <= sa_zero_reg;
            sb_norm_reg <= sa_norm_reg;
        end
    end

    twmr_round #(.WORD_BITS(W), .SIDE_BITS(SIDE1)) u_round_hi
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sb_valid_reg),
        .u1        (sb_u1_reg),
        .u0        (sb_u0_reg),
        .dn        (sb_dn_reg),
        .v         (sb_v_reg),
        .side_in   ({sb_lhi_reg, sb_llo_reg, sb_v_reg, sb_flag_reg, sb_zero_reg,
                     sb_norm_reg}),
        .out_valid (r1_valid),
        .r         (r1_r),
        .dn_out    (r1_dn),
        .side_out  (r1_side)
    );

    assign {r1_lhi, r1_llo, r1_v, r1_rest} = r1_side;

    // stage C: bring in the shifted low word
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_u1_reg   <= r1_r + r1_lhi;
            sc_u0_reg   <= r1_llo;
            sc_dn_reg   <= r1_dn;
            sc_v_reg    <= r1_v;
            sc_side_reg <= r1_rest;
        end
    end

    twmr_round #(.WORD_BITS(W), .SIDE_BITS(SIDE2)) u_round_lo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sc_valid_reg),
        .u1        (sc_u1_reg),
        .u0        (sc_u0_reg),
        .dn        (sc_dn_reg),
        .v         (sc_v_reg),
        .side_in   (sc_side_reg),
        .out_valid (r2_valid),
        .r         (r2_r),
        .dn_out    (),
        .side_out  (r2_side)
    );

    assign {r2_flag, r2_zero, r2_norm} = r2_side;

    // output register: denormalize, zero modulus gives zero
    always_comb
    begin
        out_rem_next = r2_zero ? '0 : FIELD_BITS'(r2_r >> r2_norm);
        if (r2_valid && adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r2_valid && adv)
        begin
            out_rem_reg  <= out_rem_next;
            out_flag_reg <= r2_flag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_rem_reg;
    assign m_tuser  = out_flag_reg;

endmodule

@@ rtl/twmr_mul.sv @@
// twmr_mul: two-stage WORD_BITS x WORD_BITS multiplier, full product.
// Stage 1 registers four half-word partial products, stage 2 their sum.
// Depends on twmr_pkg.
module twmr_mul
    import twmr_pkg::*;
#(
    parameter int WORD_BITS = DEFAULT_WORD_BITS
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [WORD_BITS-1:0]   a,
    input  logic [WORD_BITS-1:0]   b,
    output logic [2*WORD_BITS-1:0] p
);

    localparam int LO_BITS = WORD_BITS / 2;
    localparam int HI_BITS = WORD_BITS - LO_BITS;
    localparam int P_BITS  = 2 * WORD_BITS;

    logic [2*LO_BITS-1:0]       pp_ll_reg;
    logic [LO_BITS+HI_BITS-1:0] pp_lh_reg;
    logic [LO_BITS+HI_BITS-1:0] pp_hl_reg;
    logic [2*HI_BITS-1:0]       pp_hh_reg;
    logic [P_BITS-1:0]          p_reg;
    logic [P_BITS-1:0]          p_next;

    always_comb
    begin
        p_next = P_BITS'(pp_ll_reg)
               + (P_BITS'(pp_lh_reg) << LO_BITS)
               + (P_BITS'(pp_hl_reg) << LO_BITS)
               + (P_BITS'(pp_hh_reg) << (2 * LO_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= a[LO_BITS-1:0] * b[LO_BITS-1:0];
            pp_lh_reg <= (LO_BITS+HI_BITS)'(a[LO_BITS-1:0]) * b[WORD_BITS-1:LO_BITS];
            pp_hl_reg <= (LO_BITS+HI_BITS)'(a[WORD_BITS-1:LO_BITS]) * b[LO_BITS-1:0];
            pp_hh_reg <= a[WORD_BITS-1:LO_BITS] * b[WORD_BITS-1:LO_BITS];
            p_reg     <= p_next;
        end
    end

    assign p = p_reg;

endmodule

@@ rtl/twmr_round.sv @@
// twmr_round: one pipelined 2-by-1 reciprocal division round, 8 stages.
// Quotient estimate, back-multiply, two corrections. Passes a side vector.
// Depends on twmr_pkg and twmr_mul.
module twmr_round
    import twmr_pkg::*;
#(
    parameter int WORD_BITS = DEFAULT_WORD_BITS,
    parameter int SIDE_BITS = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [WORD_BITS-1:0] u1,
    input  logic [WORD_BITS-1:0] u0,
    input  logic [WORD_BITS-1:0] dn,
    input  logic [WORD_BITS-1:0] v,
    input  logic [SIDE_BITS-1:0] side_in,
    output logic                 out_valid,
    output logic [WORD_BITS-1:0] r,
    output logic [WORD_BITS-1:0] dn_out,
    output logic [SIDE_BITS-1:0] side_out
);

    localparam int W = WORD_BITS;

    logic [7:0] vld_reg;

    logic [2*W-1:0] prod_q;
    logic [2*W-1:0] prod_d;

    // alongside the quotient multiply
    logic [W-1:0]         u1_d1_reg, u0_d1_reg, dn_d1_reg;
    logic [SIDE_BITS-1:0] side_d1_reg;
    logic [W-1:0]         u1_d2_reg, u0_d2_reg, dn_d2_reg;
    logic [SIDE_BITS-1:0] side_d2_reg;

    // quotient estimate
    logic [W:0]           sum_wide;
    logic [W-1:0]         qh_next;
    logic [W-1:0]         qh_s3_reg, sum_s3_reg, u0_s3_reg, dn_s3_reg;
    logic [SIDE_BITS-1:0] side_s3_reg;

    // alongside the back multiply
    logic [W-1:0]         sum_d4_reg, u0_d4_reg, dn_d4_reg;
    logic [SIDE_BITS-1:0] side_d4_reg;
    logic [W-1:0]         sum_d5_reg, u0_d5_reg, dn_d5_reg;
    logic [SIDE_BITS-1:0] side_d5_reg;

    // corrections
    logic [W-1:0]         r0_next, r1_next, r2_next;
    logic [W-1:0]         r0_s6_reg, sum_s6_reg, dn_s6_reg;
    logic [SIDE_BITS-1:0] side_s6_reg;
    logic [W-1:0]         r1_s7_reg, dn_s7_reg;
    logic [SIDE_BITS-1:0] side_s7_reg;
    logic [W-1:0]         r2_s8_reg, dn_s8_reg;
    logic [SIDE_BITS-1:0] side_s8_reg;

    twmr_mul #(.WORD_BITS(W)) u_mul_q
    (
        .clk (clk),
        .en  (en),
        .a   (v),
        .b   (u1),
        .p   (prod_q)
    );

    twmr_mul #(.WORD_BITS(W)) u_mul_d
    (
        .clk (clk),
        .en  (en),
        .a   (qh_s3_reg),
        .b   (dn_s3_reg),
        .p   (prod_d)
    );

    always_comb
    begin
        // carry out of low-word add feeds the quotient word
        sum_wide = {1'b0, prod_q[W-1:0]} + {1'b0, u0_d2_reg};
        qh_next  = prod_q[2*W-1:W] + u1_d2_reg + W'(sum_wide[W]);
        // u0 - (q + 1) * d, modulo 2^W
        r0_next  = u0_d5_reg - prod_d[W-1:0] - dn_d5_reg;
        r1_next  = (r0_s6_reg > sum_s6_reg) ? (r0_s6_reg + dn_s6_reg) : r0_s6_reg;
        r2_next  = (r1_s7_reg >= dn_s7_reg) ? (r1_s7_reg - dn_s7_reg) : r1_s7_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_d1_reg   <= u1;
            u0_d1_reg   <= u0;
            dn_d1_reg   <= dn;
            side_d1_reg <= side_in;
            u1_d2_reg   <= u1_d1_reg;
            u0_d2_reg   <= u0_d1_reg;
            dn_d2_reg   <= dn_d1_reg;
            side_d2_reg <= side_d1_reg;

            qh_s3_reg   <= qh_next;
            sum_s3_reg  <= sum_wide[W-1:0];
            u0_s3_reg   <= u0_d2_reg;
            dn_s3_reg   <= dn_d2_reg;
            side_s3_reg <= side_d2_reg;

            sum_d4_reg  <= sum_s3_reg;
            u0_d4_reg   <= u0_s3_reg;
            dn_d4_reg   <= dn_s3_reg;
            side_d4_reg <= side_s3_reg;
            sum_d5_reg  <= sum_d4_reg;
            u0_d5_reg   <= u0_d4_reg;
            dn_d5_reg   <= dn_d4_reg;
            side_d5_reg <= side_d4_reg;

            r0_s6_reg   <= r0_next;
            sum_s6_reg  <= sum_d5_reg;
            dn_s6_reg   <= dn_d5_reg;
            side_s6_reg <= side_d5_reg;

            r1_s7_reg   <= r1_next;
            dn_s7_reg   <= dn_s6_reg;
            side_s7_reg <= side_s6_reg;

            r2_s8_reg   <= r2_next;
            dn_s8_reg   <= dn_s7_reg;
            side_s8_reg <= side_s7_reg;
        end
    end

    assign out_valid = vld_reg[7];
    assign r         = r2_s8_reg;
    assign dn_out    = dn_s8_reg;
    assign side_out  = side_s8_reg;

endmodule

@@ rtl/twmr_checker.sv @@
// twmr_checker: port-level assertions for the three-word modular reducer,
// bound to the top level. Depends on twmr_pkg.
module twmr_checker
    import twmr_pkg::*;
#(
    parameter int WORD_BITS = DEFAULT_WORD_BITS
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_we,
    input logic [CFG_INDEX_BITS-1:0] cfg_index,
    input logic [CFG_DATA_BITS-1:0]  cfg_data,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [FIELD_BITS-1:0]     m_tdata,
    input logic                      m_tuser
);

    logic [7:0]           in_flight_reg, in_flight_next;
    logic [WORD_BITS-1:0] mod_shadow_reg;

    always_comb
    begin
        in_flight_next = in_flight_reg + 8'(s_tvalid && s_tready) - 8'(m_tvalid && m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_flight_reg  <= '0;
            mod_shadow_reg <= WORD_BITS'(1);
        end
        else
        begin
            in_flight_reg <= in_flight_next;
            if (cfg_we && cfg_index == REG_MODULUS)
            begin
                mod_shadow_reg <= cfg_data[WORD_BITS-1:0];
            end
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input side only blocks behind a stalled, occupied output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input blocked without output stall");

    // every result traces back to an accepted transaction
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> in_flight_reg != 8'd0)
        else $error("result without accepted input");

    // remainder never exceeds the word width
    a_rem_width: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >> WORD_BITS) == '0)
        else $error("remainder wider than word");

    // zero modulus yields flagged zero remainder
    a_zero_mod: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && mod_shadow_reg == '0 |-> m_tdata == '0 && m_tuser)
        else $error("zero modulus result wrong");

endmodule

bind three_word_mod_preinv_reducer_core twmr_checker #(.WORD_BITS(WORD_BITS)) u_twmr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

@@ tb/testbench.sv @@
// testbench: self-checking regression for three_word_mod_preinv_reducer_core.
// Holds a bit-accurate remainder predictor in a small scoreboard class; drives the stream
// ports and the config port with plain tasks. Depends on twmr_pkg and the core RTL.
module testbench
    import twmr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ALL_ONES     = '1;
    localparam logic [63:0] TOP_BIT      = 64'h8000_0000_0000_0000;
    localparam int          PHASES       = 10;
    localparam int          PHASE_ITEMS  = 75;
    localparam int          HOLD_CYCLES  = 150;   // long receiver stall, well past pipe depth
    localparam int          TAIL_CYCLES  = 30;    // drain time after the last phase: pipeline depth plus margin
    localparam int          LIMIT_CYCLES = 400000;

    // one expected output transaction
    typedef struct packed {
        logic [FIELD_BITS-1:0] remainder;
        logic                  high_not_reduced;
    } reduction_t;

    // Scoreboard: mirrors both config registers, predicts each remainder at
    // input acceptance and checks output transactions in order.
    class remainder_ledger;
        logic [63:0] modulus;
        logic [63:0] inverse;
        reduction_t  pending_remainders[$];
        int          failures;
        int          flagged;

        function new();
            modulus  = 64'd1;
            inverse  = ALL_ONES;
            failures = 0;
            flagged  = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [63:0] value);
            if (idx == REG_MODULUS)
                modulus = value;
            else if (idx == REG_INVERSE)
                inverse = value;
        endfunction

        function int norm_shift(logic [63:0] x);
            int n;
            n = 0;
            while (n < 64 && !x[63-n])
                n++;
            return n;
        endfunction

        // correct inverse for a nonzero modulus: floor((2^128-1)/dn) - 2^64
        function logic [63:0] reciprocal_of(logic [63:0] d);
            logic [63:0]  dn;
            logic [127:0] q;
            dn = d << norm_shift(d);
            q  = {128{1'b1}} / {64'd0, dn};
            return q[63:0];
        endfunction

        // one 2-by-1 round; last correction is left to the caller
        function logic [63:0] divide_round(logic [63:0] u1, logic [63:0] u0,
                                           logic [63:0] dn);
            logic [127:0] prod;
            logic [64:0]  low_sum;
            logic [63:0]  qhat;
            logic [63:0]  rem;
            prod    = {64'd0, inverse} * {64'd0, u1};
            low_sum = {1'b0, prod[63:0]} + {1'b0, u0};
            qhat    = prod[127:64] + u1 + {63'd0, low_sum[64]};
            rem     = u0 - (qhat + 64'd1) * dn;
            if (rem > low_sum[63:0])
                rem = rem + dn;
            return rem;
        endfunction

        function reduction_t predict_remainder(logic [63:0] h, logic [63:0] m,
                                               logic [63:0] l);
            reduction_t  res;
            logic [63:0] dn;
            logic [63:0] u1;
            logic [63:0] u0;
            logic [63:0] r;
            int          s;
            res.high_not_reduced = (h >= modulus);
            res.remainder        = '0;
            if (modulus == 64'd0)
                return res;
            s  = norm_shift(modulus);
            dn = modulus << s;
            // first round on (high, middle)
            u1 = (h << s) + ((s == 0) ? 64'd0 : (m >> (64 - s)));
            u0 = m << s;
            r  = divide_round(u1, u0, dn);
            if (r >= dn)
                r = r - dn;
            // second round on (partial remainder, low)
            u1 = r + ((s == 0) ? 64'd0 : (l >> (64 - s)));
            u0 = l << s;
            r  = divide_round(u1, u0, dn);
            if (r >= dn)
                r = r - dn;
            res.remainder = r >> s;
            return res;
        endfunction

        function void note_dividend(logic [63:0] h, logic [63:0] m, logic [63:0] l);
            reduction_t expected;
            expected = predict_remainder(h, m, l);
            if (expected.high_not_reduced)
                flagged++;
            pending_remainders.push_back(expected);
        endfunction

        function void check_result(logic [FIELD_BITS-1:0] rem, logic flag);
            reduction_t expected;
            if (pending_remainders.size() == 0)
            begin
                $display("%0t: unexpected result, nothing pending: remainder %h flag %b",
                         $time, rem, flag);
                failures++;
                return;
            end
            expected = pending_remainders.pop_front();
            if (rem !== expected.remainder)
            begin
                $display("%0t: remainder mismatch: expected %h, actual %h",
                         $time, expected.remainder, rem);
                failures++;
            end
            if (flag !== expected.high_not_reduced)
            begin
                $display("%0t: high_not_reduced mismatch: expected %b, actual %b",
                         $time, expected.high_not_reduced, flag);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_remainders.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [3*FIELD_BITS-1:0]   s_tdata = '0;    // word_high, word_middle, word_low
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [FIELD_BITS-1:0]     m_tdata;         // remainder
    logic                      m_tuser;         // high_not_reduced

    remainder_ledger sb;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    bit              hold_start = 1'b0;
    int              hold_left = 0;
    int              dividends_sent = 0;
    int              settings_used = 0;
    int              input_stall_cycles = 0;

    three_word_mod_preinv_reducer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: random stalls at recv_idle_pct, or a long hold-off counted
    // here once the main sequence requests it.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_start)
        begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Output monitor: every accepted output transaction goes to the scoreboard; input stalls are counted too.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if (rst_n && s_tvalid && !s_tready)
            input_stall_cycles++;
    end

    // Watchdog
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still pending",
                 LIMIT_CYCLES, sb.outstanding());
        $display("three_word_mod_preinv_reducer_core regression: fail");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly random, with the two extremes showing up now and then
    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return ALL_ONES;
            default: return rand64();
        endcase
    endfunction

    // nonzero modulus with a random number of leading zeros
    function automatic logic [63:0] random_modulus();
        logic [63:0] d;
        d = rand64() >> $urandom_range(0, 63);
        return (d == 64'd0) ? 64'd1 : d;
    endfunction

    // config write; the block must be idle
    task automatic set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(logic [63:0] modulus, logic [63:0] inverse);
        set_register(REG_MODULUS, modulus);
        set_register(REG_INVERSE, inverse);
        settings_used++;
    endtask

    // Offer one dividend; returns right after the input transaction is taken.
    // s_tvalid stays high so a back-to-back transaction needs no re-raise.
    task automatic offer_dividend(logic [63:0] h, logic [63:0] m, logic [63:0] l);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {l, m, h};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_dividend(h, m, l);
        dividends_sent++;
    endtask

    // drop valid and wait for every pending result
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    // random dividend: high word mostly below the modulus, some noise above
    task automatic offer_random(logic [63:0] modulus);
        logic [63:0] h;
        if (modulus != 64'd0 && $urandom_range(0, 99) < 88)
            h = ($urandom_range(0, 9) == 0) ? modulus - 64'd1 : rand64() % modulus;
        else
            h = pick_word();
        offer_dividend(h, pick_word(), pick_word());
    endtask

    initial
    begin
        logic [63:0] d;
        logic [63:0] v;
        sb = new();

        // hold reset, then release it
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // --- directed part, no idling on either stream side ---
        recv_idle_pct = 0;
        send_idle_pct = 0;

        // reset values: modulus 1 with its matching inverse
        offer_dividend(64'd0, 64'd0, 64'd0);
        offer_dividend(ALL_ONES, ALL_ONES, ALL_ONES);   // high word not reduced
        offer_dividend(64'd0, ALL_ONES, ALL_ONES);
        settle();

        // largest modulus, no normalizing shift
        configure(ALL_ONES, sb.reciprocal_of(ALL_ONES));
        offer_dividend(ALL_ONES - 64'd1, ALL_ONES, ALL_ONES);
        offer_dividend(64'd0, 64'd0, ALL_ONES);
        offer_dividend(ALL_ONES, 64'd0, 64'd0);          // high equals modulus
        offer_dividend(ALL_ONES - 64'd1, 64'd0, 64'd0);
        settle();

        // already normalized power of two
        configure(TOP_BIT, sb.reciprocal_of(TOP_BIT));
        offer_dividend(TOP_BIT - 64'd1, ALL_ONES, ALL_ONES);
        offer_dividend(TOP_BIT, 64'd1, 64'd1);
        settle();

        // tiny modulus, shift of 62
        configure(64'd3, sb.reciprocal_of(64'd3));
        offer_dividend(64'd2, ALL_ONES, ALL_ONES);
        offer_dividend(64'd0, 64'd0, 64'd2);
        offer_dividend(64'd3, 64'd5, 64'd7);
        settle();

        // zero modulus: flag set, remainder zero
        configure(64'd0, ALL_ONES);
        offer_dividend(64'd0, 64'd0, 64'd0);
        offer_dividend(ALL_ONES, ALL_ONES, ALL_ONES);
        settle();

        // inverse that does not match the modulus
        d = random_modulus();
        configure(d, 64'd0);
        offer_dividend(rand64() % d, rand64(), rand64());
        offer_dividend(d - 64'd1, ALL_ONES, ALL_ONES);
        settle();
        configure(d, rand64());
        offer_dividend(rand64() % d, rand64(), rand64());
        offer_dividend(rand64() % d, 64'd0, ALL_ONES);
        settle();

        // --- random part: one register setting per phase ---
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 3)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 81;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (phase)
                0: d = 64'($urandom_range(1, 255));
                2: d = ALL_ONES;
                3: d = TOP_BIT | (rand64() >> 1);
                4: d = {32'd0, $urandom} | 64'd1;
                6: d = 64'd0;
                default: d = random_modulus();
            endcase
            // phase 5 runs a wrong inverse, phase 6 a zero modulus
            v = (phase == 5 || phase == 6) ? rand64() : sb.reciprocal_of(d);
            configure(d, v);

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // long receiver hold-off while the sender keeps pushing
                if (phase == 7 && i == 20)
                    hold_start = 1'b1;
                // sender pauses until the pipe is empty
                if (phase == 8 && i == 30)
                    settle();
                offer_random(d);
            end
            settle();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.outstanding() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, sb.outstanding());
            sb.failures++;
        end

        $display("covered %0d dividends over %0d register settings, %0d with high word >= modulus",
                 dividends_sent, settings_used + 1, sb.flagged);
        $display("input held off by backpressure for %0d cycles, %0d check failures",
                 input_stall_cycles, sb.failures);
        if (sb.failures == 0)
            $display("three_word_mod_preinv_reducer_core regression: pass");
        else
            $display("three_word_mod_preinv_reducer_core regression: fail");
        $finish;
    end

endmodule

@@ three_word_mod_preinv_reducer_core.f @@
rtl/twmr_pkg.sv
rtl/twmr_mul.sv
rtl/twmr_round.sv
rtl/three_word_mod_preinv_reducer_core.sv
rtl/twmr_checker.sv
tb/testbench.sv
